FILE: rtl/core/free_list_slot_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// Free-list slot allocator assertion macros
// Shared assertion forms for the allocator core, clocked on the rising edge
// of i_clk and held off while the synchronous reset i_rst_n is asserted.
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define FREE_LIST_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication
`define FLA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FLA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fla_pkg.sv
// ----------------------------------------------------------------------------
// Free-list slot allocator package
// Beat types, status codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fla_pkg;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_COUNT = 2'd1,
        ST_TOO_FEW    = 2'd2,
        ST_UNDERFLOW  = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WALK
    } t_state;

    // Request beat
    typedef struct packed {
        logic       op;
        logic [8:0] count;
        logic [7:0] slot;
    } t_in_item;

    // Result beat
    typedef struct packed {
        t_status    status;
        logic [7:0] run_first;
        logic [7:0] run_last;
        logic [8:0] used_count;
        logic [8:0] peak_used;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_in;
        logic    clr_step;
        logic    walk_start;
        logic    walk_step;
        logic    free_commit;
        logic    alloc_commit;
        logic    res_load;
        t_status res_status;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic used_zero;
        logic count_zero;
        logic too_few;
        logic walk_more;
        logic link_null;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/core/free_list_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// Free-list slot allocator core
// Keeps a pool of slots on a linked free list; allocates runs from the head
// and pushes freed slots back, reporting usage and its high-water mark.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_in_valid / o_in_ready carries one beat with op, count
//   and slot. Result channel o_out_valid / i_out_ready returns exactly one
//   beat per request: status, first and last slot of a run, used count and
//   peak used count after the request.
//   After reset the link memory is initialized by a sweep over all
//   POOL_SLOTS entries, one entry per cycle; o_in_ready stays low
//   until it ends. A free, a zero-count or a rejected allocate is decided
//   in the execute state after accept. An allocate walks from the head,
//   following one link per cycle through the single read port of the
//   link memory. A walk that hits the end of the list early stops there.
//   One request is in flight at a time; the next is accepted as soon as
//   the result is written to the output register, even while that result
//   waits. A stalled receiver holds the result and stalls the next request
//   at its final step.
// ----------------------------------------------------------------------------
`include "free_list_slot_allocator_core_defines.svh"

module free_list_slot_allocator_core #(
    parameter int POOL_SLOTS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fla_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fla_pkg::t_out_item o_out_item
);

    fla_pkg::t_dp_cmd dp_cmd;
    fla_pkg::t_dp_sts dp_sts;
    logic [4:0]       dp_ops;
    logic             out_open;

    // Sequencer
    fla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Link memory, counters and result register
    fla_dpath #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Gather the link memory commands and the output slot state for checks
    assign dp_ops   = {dp_cmd.clr_step, dp_cmd.walk_start, dp_cmd.walk_step,
                       dp_cmd.free_commit, dp_cmd.alloc_commit};
    assign out_open = !o_out_valid || i_out_ready;

    // Checks
    `FLA_ASSERT_IMPL(a_cmd_exclusive, 1'b1, $onehot0(dp_ops), "datapath commands overlap")
    `FLA_ASSERT_IMPL(a_no_overwrite, dp_cmd.res_load, out_open, "result over a waiting beat")
    `FLA_ASSERT_IMPL(a_walk_not_null, dp_cmd.walk_step, !dp_sts.link_null, "walk stepped onto null")
    `FLA_ASSERT_NEXT(a_res_shows, dp_cmd.res_load, o_out_valid, "loaded result not presented")

endmodule

FILE: rtl/core/fla_ctrl.sv
// ----------------------------------------------------------------------------
// Free-list slot allocator controller
// Sequences the clearing pass, request capture, free and allocate decisions
// and the link walk, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module fla_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  fla_pkg::t_dp_sts i_sts,
    output fla_pkg::t_dp_cmd o_cmd
);

    fla_pkg::t_state r_state;
    fla_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fla_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.res_status = fla_pkg::ST_OK;
        case (r_state)
            fla_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = fla_pkg::S_IDLE;
                end
            end
            fla_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = fla_pkg::S_EXEC;
                end
            end
            fla_pkg::S_EXEC: begin
                if (i_sts.is_free) begin
                    // Push one slot, or report underflow
                    if (i_sts.out_free) begin
                        o_cmd.res_load = 1'b1;
                        n_state        = fla_pkg::S_IDLE;
                        if (i_sts.used_zero) begin
                            o_cmd.res_status = fla_pkg::ST_UNDERFLOW;
                        end else begin
                            o_cmd.free_commit = 1'b1;
                        end
                    end
                end else if (i_sts.count_zero) begin
                    if (i_sts.out_free) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = fla_pkg::ST_ZERO_COUNT;
                        n_state          = fla_pkg::S_IDLE;
                    end
                end else if (i_sts.too_few) begin
                    if (i_sts.out_free) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = fla_pkg::ST_TOO_FEW;
                        n_state          = fla_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = fla_pkg::S_WALK;
                end
            end
            fla_pkg::S_WALK: begin
                if (i_sts.walk_more) begin
                    // Follow one link, drop the run if the list ends early
                    if (i_sts.link_null) begin
                        if (i_sts.out_free) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = fla_pkg::ST_TOO_FEW;
                            n_state          = fla_pkg::S_IDLE;
                        end
                    end else begin
                        o_cmd.walk_step = 1'b1;
                    end
                end else if (i_sts.out_free) begin
                    o_cmd.alloc_commit = 1'b1;
                    o_cmd.res_load     = 1'b1;
                    n_state            = fla_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fla_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

FILE: rtl/core/fla_dpath.sv
// ----------------------------------------------------------------------------
// Free-list slot allocator datapath
// Holds the link memory, free-list head, usage counters, walk registers
// and the result register.
// ----------------------------------------------------------------------------
module fla_dpath #(
    parameter int POOL_SLOTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fla_pkg::t_in_item   i_in_item,
    input  fla_pkg::t_dp_cmd    i_cmd,
    output fla_pkg::t_dp_sts    o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fla_pkg::t_out_item  o_out_item
);

    localparam int SW = (POOL_SLOTS > 2) ? $clog2(POOL_SLOTS) : 1;
    localparam int LW = $clog2(POOL_SLOTS + 1);
    localparam int KW = (LW > 9) ? LW : 9;
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_SLOTS);
    localparam logic [SW-1:0] END_SLOT  = SW'(POOL_SLOTS - 1);

    logic [LW-1:0] r_link [POOL_SLOTS];
    logic [LW-1:0] r_rd_data;

    fla_pkg::t_in_item  r_in;
    fla_pkg::t_out_item r_out;
    logic               r_out_valid;
    logic [LW-1:0]      r_head;
    logic [LW-1:0]      r_used;
    logic [LW-1:0]      n_used;
    logic [LW-1:0]      r_peak;
    logic [LW-1:0]      n_peak;
    logic [SW-1:0]      r_clr;
    logic [SW-1:0]      r_cur;
    logic [SW-1:0]      r_first;
    logic [KW-1:0]      r_left;

    logic [SW-1:0] slot_idx;
    logic [LW-1:0] free_cnt;
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic [LW-1:0] wr_data;

    // Wrap the freed slot index into the pool
    if (POOL_SLOTS >= 256) begin : g_slot_wide
        assign slot_idx = SW'(r_in.slot);
    end else begin : g_slot_wrap
        logic [SW-1:0] mod_lut [256];
        for (genvar g = 0; g < 256; g++) begin : g_lut
            assign mod_lut[g] = SW'(g % POOL_SLOTS);
        end
        assign slot_idx = mod_lut[r_in.slot];
    end

    // Status toward the controller
    assign free_cnt          = NULL_LINK - r_used;
    assign o_sts.clr_last    = (r_clr == END_SLOT);
    assign o_sts.is_free     = (r_in.op == fla_pkg::OP_FREE);
    assign o_sts.used_zero   = (r_used == '0);
    assign o_sts.count_zero  = (r_in.count == '0);
    assign o_sts.too_few     = (KW'(r_in.count) > KW'(free_cnt)) || (r_head >= NULL_LINK);
    assign o_sts.walk_more   = (r_left > KW'(1));
    assign o_sts.link_null   = (r_rd_data >= NULL_LINK);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    // Link memory port selection
    always_comb begin
        rd_en   = i_cmd.walk_start || i_cmd.walk_step;
        rd_addr = i_cmd.walk_step ? r_rd_data[SW-1:0] : r_head[SW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_clr;
        wr_data = LW'(r_clr) + LW'(1);
        if (i_cmd.free_commit) begin
            wr_en   = 1'b1;
            wr_addr = slot_idx;
            wr_data = r_head;
        end else if (i_cmd.alloc_commit) begin
            wr_en   = 1'b1;
            wr_addr = r_cur;
            wr_data = NULL_LINK;
        end else if (i_cmd.clr_step) begin
            wr_en   = 1'b1;
        end
    end

    // Link memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_link[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_link[rd_addr];
        end
    end

    // Next usage counters
    always_comb begin
        n_used = r_used;
        n_peak = r_peak;
        if (i_cmd.free_commit) begin
            n_used = r_used - LW'(1);
        end else if (i_cmd.alloc_commit) begin
            n_used = r_used + LW'(r_in.count);
        end
        if (n_used > r_peak) begin
            n_peak = n_used;
        end
    end

    // Control state: head, counters, clear sweep, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_used      <= '0;
            r_peak      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_used <= n_used;
            r_peak <= n_peak;
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + SW'(1);
            end
            if (i_cmd.free_commit) begin
                r_head <= LW'(slot_idx);
            end else if (i_cmd.alloc_commit) begin
                r_head <= r_rd_data;
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: request capture, walk registers, result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_item;
        end
        if (i_cmd.walk_start) begin
            r_cur   <= r_head[SW-1:0];
            r_first <= r_head[SW-1:0];
            r_left  <= KW'(r_in.count);
        end else if (i_cmd.walk_step) begin
            r_cur  <= r_rd_data[SW-1:0];
            r_left <= r_left - KW'(1);
        end
        if (i_cmd.res_load) begin
            r_out.status     <= i_cmd.res_status;
            r_out.run_first  <= i_cmd.alloc_commit ? 8'(r_first) : 8'd0;
            r_out.run_last   <= i_cmd.alloc_commit ? 8'(r_cur) : 8'd0;
            r_out.used_count <= 9'(n_used);
            r_out.peak_used  <= 9'(n_peak);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
